@@ hw/rtl/bounded_char_sequence_editor_core_assert.svh @@
// Assertion macros for the byte-sequence editor.
// They sample on clk and are disabled while arst_n is low.
`ifndef BOUNDED_CHAR_SEQUENCE_EDITOR_CORE_ASSERT_SVH
`define BOUNDED_CHAR_SEQUENCE_EDITOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BCSE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcse: same-cycle check failed");
`define BCSE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcse: next-cycle check failed");
`else
`define BCSE_ASSERT_IMP(lbl, ante, cons)
`define BCSE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/bcse_pkg.sv @@
package bcse_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int QUEUE_DEPTH  = 2;

	localparam int REQ_TYPE_W = 3;
	localparam int POS_W      = 5;
	localparam int CHAR_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int FILL_W     = 6;

	// Request codes as they arrive on the request channel.
	localparam logic [REQ_TYPE_W-1:0] REQ_APPEND = 3'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_MODIFY = 3'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_DELETE = 3'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 3'd3;
	localparam logic [REQ_TYPE_W-1:0] REQ_DUMP   = 3'd4;
	localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 3'd5;

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_MODIFY,
		OP_DELETE,
		OP_INSERT,
		OP_DUMP,
		OP_CLEAR,
		OP_INVALID
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE,
		STATUS_REJECT,
		STATUS_EMPTY
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [POS_W-1:0]  pos;
		logic [CHAR_W-1:0] ch;
	} cmd_t;

endpackage

@@ hw/rtl/bcse_req_if.sv @@
interface bcse_req_if;
	logic                               valid;
	logic                               ready;
	logic [bcse_pkg::REQ_TYPE_W-1:0]    req_type;
	logic [bcse_pkg::POS_W-1:0]         position;
	logic [bcse_pkg::CHAR_W-1:0]        data_char;

	modport source (output valid, output req_type, output position, output data_char,
		input ready);
	modport sink (input valid, input req_type, input position, input data_char,
		output ready);
endinterface

@@ hw/rtl/bcse_rsp_if.sv @@
interface bcse_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [bcse_pkg::STATUS_W-1:0]      status;
	logic [bcse_pkg::CHAR_W-1:0]        out_char;
	logic [bcse_pkg::POS_W-1:0]         out_position;
	logic [bcse_pkg::FILL_W-1:0]        fill_after;
	logic                               last;

	modport source (output valid, output status, output out_char, output out_position,
		output fill_after, output last, input ready);
	modport sink (input valid, input status, input out_char, input out_position,
		input fill_after, input last, output ready);
endinterface

@@ hw/rtl/bcse_front.sv @@
module bcse_front (
	input  logic            clk,
	input  logic            arst_n,
	bcse_req_if.sink        req,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output bcse_pkg::cmd_t  cmd
);

	localparam int DEPTH = bcse_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bcse_pkg::cmd_t   q_mem [DEPTH];
	bcse_pkg::cmd_t   cmd_in;
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	// Classify the request code; unused codes become a reject in the back part.
	always_comb begin
		cmd_in.pos = req.position;
		cmd_in.ch  = req.data_char;
		case (req.req_type)
			bcse_pkg::REQ_APPEND: cmd_in.op = bcse_pkg::OP_APPEND;
			bcse_pkg::REQ_MODIFY: cmd_in.op = bcse_pkg::OP_MODIFY;
			bcse_pkg::REQ_DELETE: cmd_in.op = bcse_pkg::OP_DELETE;
			bcse_pkg::REQ_INSERT: cmd_in.op = bcse_pkg::OP_INSERT;
			bcse_pkg::REQ_DUMP:   cmd_in.op = bcse_pkg::OP_DUMP;
			bcse_pkg::REQ_CLEAR:  cmd_in.op = bcse_pkg::OP_CLEAR;
			default:              cmd_in.op = bcse_pkg::OP_INVALID;
		endcase
	end

	assign req.ready = (cnt_q != CNT_W'(DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rd_ptr_q];
	assign push      = req.valid && req.ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

@@ hw/rtl/bcse_back.sv @@
module bcse_back #(
	parameter int CAPACITY = bcse_pkg::CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  bcse_pkg::cmd_t  cmd,
	bcse_rsp_if.source      rsp
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int POS_W  = bcse_pkg::POS_W;
	localparam int CHAR_W = bcse_pkg::CHAR_W;
	localparam int FILL_W = bcse_pkg::FILL_W;
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic {
		S_EXEC,
		S_DUMP
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q, cnt_nxt;
	logic [IDX_W-1:0]       idx_q, rd_idx;
	logic [CHAR_W-1:0]      cell_q   [CAPACITY];
	logic [CHAR_W-1:0]      cell_nxt [CAPACITY];
	logic [CHAR_W-1:0]      rd_char;
	logic                   rd_last;
	logic                   out_free, take, full, pos_ok, edit_ok;
	logic [CMP_W-1:0]       pos_ext, cnt_ext;
	bcse_pkg::status_t      status_nxt;

	logic                   rsp_valid_q;
	logic [bcse_pkg::STATUS_W-1:0] status_q;
	logic [CHAR_W-1:0]      char_q;
	logic [POS_W-1:0]       opos_q;
	logic [FILL_W-1:0]      fill_q;
	logic                   last_q;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign cmd_ready = out_free && (state_q == S_EXEC);
	assign take      = cmd_valid && cmd_ready;

	assign pos_ext = CMP_W'(cmd.pos);
	assign cnt_ext = CMP_W'(cnt_q);
	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign pos_ok  = (pos_ext < cnt_ext);

	always_comb begin
		edit_ok    = 1'b0;
		cnt_nxt    = cnt_q;
		status_nxt = bcse_pkg::STATUS_DONE;
		case (cmd.op)
			bcse_pkg::OP_APPEND: begin
				if (!full) begin
					edit_ok = 1'b1;
					cnt_nxt = cnt_q + 1'b1;
				end else begin
					status_nxt = bcse_pkg::STATUS_REJECT;
				end
			end
			bcse_pkg::OP_MODIFY: begin
				if (pos_ok) begin
					edit_ok = 1'b1;
				end else begin
					status_nxt = bcse_pkg::STATUS_REJECT;
				end
			end
			bcse_pkg::OP_DELETE: begin
				if (pos_ok) begin
					edit_ok = 1'b1;
					cnt_nxt = cnt_q - 1'b1;
				end else begin
					status_nxt = bcse_pkg::STATUS_REJECT;
				end
			end
			bcse_pkg::OP_INSERT: begin
				if (pos_ok && !full) begin
					edit_ok = 1'b1;
					cnt_nxt = cnt_q + 1'b1;
				end else begin
					status_nxt = bcse_pkg::STATUS_REJECT;
				end
			end
			bcse_pkg::OP_DUMP: begin
				if (cnt_q == '0) begin
					status_nxt = bcse_pkg::STATUS_EMPTY;
				end
			end
			bcse_pkg::OP_CLEAR: cnt_nxt = '0;
			default:            status_nxt = bcse_pkg::STATUS_REJECT;
		endcase
	end

	// Each cell picks its next value from itself, the incoming byte or a neighbour.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [CMP_W-1:0]  here;
		logic [CHAR_W-1:0] up, dn;
		logic              wr_here, shl, shr;

		if (g < CAPACITY - 1) begin : g_up
			assign up = cell_q[g + 1];
		end else begin : g_up_end
			assign up = cell_q[g];
		end
		if (g > 0) begin : g_dn
			assign dn = cell_q[g - 1];
		end else begin : g_dn_end
			assign dn = cell_q[g];
		end

		assign here    = CMP_W'(g);
		assign wr_here = ((cmd.op == bcse_pkg::OP_APPEND) && (here == cnt_ext))
			|| ((cmd.op == bcse_pkg::OP_MODIFY) && (here == pos_ext))
			|| ((cmd.op == bcse_pkg::OP_INSERT) && (here == pos_ext));
		assign shl = (cmd.op == bcse_pkg::OP_DELETE) && (here >= pos_ext);
		assign shr = (cmd.op == bcse_pkg::OP_INSERT) && (here > pos_ext);

		assign cell_nxt[g] = !(take && edit_ok) ? cell_q[g] :
			wr_here ? cmd.ch :
			shl     ? up :
			shr     ? dn : cell_q[g];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_q[i] <= cell_nxt[i];
		end
	end

	assign rd_idx  = (state_q == S_DUMP) ? idx_q : '0;
	assign rd_char = cell_q[rd_idx];
	assign rd_last = ((CNT_W'(rd_idx) + 1'b1) == cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_EXEC;
			cnt_q       <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= '0;
			char_q      <= '0;
			opos_q      <= '0;
			fill_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_EXEC: begin
					if (take) begin
						rsp_valid_q <= 1'b1;
						cnt_q       <= cnt_nxt;
						status_q    <= status_nxt;
						fill_q      <= FILL_W'(cnt_nxt);
						char_q      <= '0;
						opos_q      <= '0;
						last_q      <= 1'b1;
						if ((cmd.op == bcse_pkg::OP_DUMP) && (cnt_q != '0)) begin
							char_q <= rd_char;
							last_q <= rd_last;
							if (!rd_last) begin
								state_q <= S_DUMP;
								idx_q   <= IDX_W'(1);
							end
						end
					end
				end
				S_DUMP: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						char_q      <= rd_char;
						opos_q      <= POS_W'(rd_idx);
						last_q      <= rd_last;
						idx_q       <= idx_q + 1'b1;
						if (rd_last) begin
							state_q <= S_EXEC;
						end
					end
				end
				default: state_q <= S_EXEC;
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_char     = char_q;
	assign rsp.out_position = opos_q;
	assign rsp.fill_after   = fill_q;
	assign rsp.last         = last_q;

endmodule

@@ hw/rtl/bounded_char_sequence_editor_core.sv @@
// Bounded byte-sequence editor: keeps up to CAPACITY bytes in order with a fill count.
// Requests arrive on the req channel (req_type, position, data_char) and results leave
// on the rsp channel (status, out_char, out_position, fill_after, last); both channels
// move one beat when valid and ready are high at the same rising edge of clk.
// Append, modify, delete, insert and clear each give exactly one beat with last set.
// A dump gives one beat per stored byte, in order, with last on the final one, or a
// single beat with the empty status when nothing is stored.
// A request is first written into the queue and then executed into the output
// register. Edits are taken one per cycle while the receiver does not hold the result,
// since every cell moves in the same cycle; a dump holds the back part until each stored
// byte has been read, one per beat, through the single read port of the cell row.
// Reset (arst_n low) empties the sequence and the queue; byte contents are not
// cleared, as nothing past the fill count is ever read.
// When the receiver stalls, the result beat is held and the two-entry queue between
// the front and back parts fills, after which req.ready falls.
module bounded_char_sequence_editor_core #(
	parameter int CAPACITY = bcse_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bcse_req_if.sink    req,
	bcse_rsp_if.source  rsp
);

`include "bounded_char_sequence_editor_core_assert.svh"

	localparam int FCMP_W = bcse_pkg::FILL_W + 1;

	// Classified commands pass from the front part to the back part here.
	logic            cmd_valid;
	logic            cmd_ready;
	bcse_pkg::cmd_t  cmd;

	// Front part: takes request beats, decodes the code and queues the command.
	bcse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Back part: the cell row, the fill count and the result register.
	bcse_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp       (rsp)
	);

	// The fill count reported never exceeds the capacity.
	`BCSE_ASSERT_IMP(a_fill_bound, rsp.valid, FCMP_W'(rsp.fill_after) <= FCMP_W'(CAPACITY))
	// A rejected request carries no byte and closes its own result.
	`BCSE_ASSERT_IMP(a_reject_shape, rsp.valid && (rsp.status == bcse_pkg::STATUS_REJECT), rsp.last && (rsp.out_char == '0))
	// While a dump has bytes left to send, the back part takes no new command.
	`BCSE_ASSERT_IMP(a_dump_blocks, rsp.valid && !rsp.last, !cmd_ready)
	// A clear shows up next cycle as a result with an empty sequence.
	`BCSE_ASSERT_NXT(a_clear_empties, cmd_valid && cmd_ready && (cmd.op == bcse_pkg::OP_CLEAR), rsp.valid && (rsp.fill_after == '0))

endmodule
